[hdl/erm_pkg.sv]
// Shared types, constants and functions of the Euler rotation matrix builder.
package erm_pkg;

  localparam int ANGLE_W   = 16;
  localparam int PHASE_W   = 12;
  localparam int TRIG_W    = 14;
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 2 * TRIG_W;
  localparam int MPROD_W   = TRIG_W + ELEM_W;
  localparam int ACC_W     = 32;
  localparam int FRAC_BITS = 12;
  localparam int QTR_LAST  = 1024;
  localparam int QADDR_W   = 11;
  localparam int ROM_W     = 13;
  localparam int LATENCY   = 5;
  localparam int ELEM_MAX  = 32767;
  localparam int ELEM_MIN  = -32768;

  typedef logic signed [TRIG_W-1:0]  trig_t;
  typedef logic signed [ELEM_W-1:0]  elem_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [MPROD_W-1:0] mprod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic [ROM_W-1:0]          qsin_tab_t [0:QTR_LAST];

  // sine and cosine of one angle
  typedef struct packed {
    trig_t s;
    trig_t c;
  } sc_t;

  // quarter-wave table: round(sin(pi*r/2048) * 4096) for r in 0..1024
  function automatic qsin_tab_t qsin_build();
    qsin_tab_t tab;
    real       x;
    real       x2;
    real       sv;
    for (int r = 0; r <= QTR_LAST; r++) begin
      x  = 3.14159265358979323846 * r / 2048.0;
      x2 = x * x;
      sv = x * (1.0 - x2 / 6.0 * (1.0 - x2 / 20.0 * (1.0 - x2 / 42.0 *
           (1.0 - x2 / 72.0 * (1.0 - x2 / 110.0 * (1.0 - x2 / 156.0 *
           (1.0 - x2 / 210.0 * (1.0 - x2 / 272.0 * (1.0 - x2 / 342.0)))))))));
      tab[r] = ROM_W'($rtoi(sv * 4096.0 + 0.5));
    end
    return tab;
  endfunction

  // arithmetic shift right by 12 (floor), then saturate to signed 16 bits
  function automatic elem_t sat_shr12(acc_t v);
    logic signed [ACC_W-FRAC_BITS-1:0] sh;
    elem_t res;
    sh = v[ACC_W-1:FRAC_BITS];
    if (sh > ELEM_MAX) begin
      res = elem_t'(ELEM_MAX);
    end else if (sh < ELEM_MIN) begin
      res = elem_t'(ELEM_MIN);
    end else begin
      res = sh[ELEM_W-1:0];
    end
    return res;
  endfunction

endpackage

[hdl/erm_sincos_lane.sv]
// One angle lane: quarter-wave ROM lookup of sine and cosine with quadrant folding.
module erm_sincos_lane (
  input  logic                              clk,
  input  logic signed [erm_pkg::ANGLE_W-1:0] angle_i,
  output erm_pkg::sc_t                      sc_o
);

  localparam erm_pkg::qsin_tab_t QSIN = erm_pkg::qsin_build();

  logic [erm_pkg::PHASE_W-1:0] k_s;
  logic [erm_pkg::PHASE_W-1:0] k_c;
  logic [erm_pkg::QADDR_W-1:0] addr_s;
  logic [erm_pkg::QADDR_W-1:0] addr_c;
  logic [erm_pkg::ROM_W-1:0]   rom_s_r;
  logic [erm_pkg::ROM_W-1:0]   rom_c_r;
  logic                        neg_s_r;
  logic                        neg_c_r;
  erm_pkg::trig_t              val_s;
  erm_pkg::trig_t              val_c;
  erm_pkg::sc_t                sc_r;

  // cosine is the sine a quarter turn further on
  assign k_s = angle_i[erm_pkg::PHASE_W-1:0];
  assign k_c = k_s + erm_pkg::PHASE_W'(erm_pkg::QTR_LAST);

  // odd quadrants read the table backwards
  assign addr_s = k_s[erm_pkg::PHASE_W-2] ?
      (erm_pkg::QADDR_W'(erm_pkg::QTR_LAST) - {1'b0, k_s[erm_pkg::PHASE_W-3:0]}) :
      {1'b0, k_s[erm_pkg::PHASE_W-3:0]};
  assign addr_c = k_c[erm_pkg::PHASE_W-2] ?
      (erm_pkg::QADDR_W'(erm_pkg::QTR_LAST) - {1'b0, k_c[erm_pkg::PHASE_W-3:0]}) :
      {1'b0, k_c[erm_pkg::PHASE_W-3:0]};

  always_ff @(posedge clk) begin
    rom_s_r <= QSIN[addr_s];
    rom_c_r <= QSIN[addr_c];
    neg_s_r <= k_s[erm_pkg::PHASE_W-1];
    neg_c_r <= k_c[erm_pkg::PHASE_W-1];
  end

  assign val_s = erm_pkg::trig_t'({1'b0, rom_s_r});
  assign val_c = erm_pkg::trig_t'({1'b0, rom_c_r});

  // upper half turn is negative
  always_ff @(posedge clk) begin
    sc_r.s <= neg_s_r ? -val_s : val_s;
    sc_r.c <= neg_c_r ? -val_c : val_c;
  end

  assign sc_o = sc_r;

endmodule

[hdl/erm_mat_merge.sv]
// Merge stage: forms Rx*Ry, then Rz times that product, over three registered steps.
module erm_mat_merge (
  input  logic           clk,
  input  erm_pkg::sc_t   sc_x_i,
  input  erm_pkg::sc_t   sc_y_i,
  input  erm_pkg::sc_t   sc_z_i,
  output erm_pkg::elem_t m_o [9]
);

  // step one: the four products that Rx*Ry needs
  erm_pkg::prod_t sxsy_r;
  erm_pkg::prod_t sxcy_r;
  erm_pkg::prod_t cxsy_r;
  erm_pkg::prod_t cxcy_r;
  erm_pkg::trig_t sx_r;
  erm_pkg::trig_t cx_r;
  erm_pkg::trig_t sy_r;
  erm_pkg::trig_t cy_r;
  erm_pkg::trig_t sz_r;
  erm_pkg::trig_t cz_r;

  always_ff @(posedge clk) begin
    sxsy_r <= sc_x_i.s * sc_y_i.s;
    sxcy_r <= sc_x_i.s * sc_y_i.c;
    cxsy_r <= sc_x_i.c * sc_y_i.s;
    cxcy_r <= sc_x_i.c * sc_y_i.c;
    sx_r   <= sc_x_i.s;
    cx_r   <= sc_x_i.c;
    sy_r   <= sc_y_i.s;
    cy_r   <= sc_y_i.c;
    sz_r   <= sc_z_i.s;
    cz_r   <= sc_z_i.c;
  end

  // rows of P = Rx*Ry; unit entries pass exactly through the shift
  erm_pkg::elem_t p0 [3];
  erm_pkg::elem_t p1 [3];
  erm_pkg::elem_t p2 [3];

  always_comb begin
    p0[0] = erm_pkg::ELEM_W'(cy_r);
    p0[1] = '0;
    p0[2] = erm_pkg::ELEM_W'(sy_r);
    p1[0] = erm_pkg::sat_shr12(erm_pkg::ACC_W'(sxsy_r));
    p1[1] = erm_pkg::ELEM_W'(cx_r);
    p1[2] = erm_pkg::sat_shr12(-erm_pkg::ACC_W'(sxcy_r));
    p2[0] = erm_pkg::sat_shr12(-erm_pkg::ACC_W'(cxsy_r));
    p2[1] = erm_pkg::ELEM_W'(sx_r);
    p2[2] = erm_pkg::sat_shr12(erm_pkg::ACC_W'(cxcy_r));
  end

  // step two: Rz products on the top two rows, bottom row passes unchanged
  erm_pkg::mprod_t czp0_r [3];
  erm_pkg::mprod_t szp1_r [3];
  erm_pkg::mprod_t szp0_r [3];
  erm_pkg::mprod_t czp1_r [3];
  erm_pkg::elem_t  p2_r   [3];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      czp0_r[j] <= cz_r * p0[j];
      szp1_r[j] <= sz_r * p1[j];
      szp0_r[j] <= sz_r * p0[j];
      czp1_r[j] <= cz_r * p1[j];
      p2_r[j]   <= p2[j];
    end
  end

  // step three: sum, shift and saturate into the result register
  erm_pkg::elem_t m_r [9];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      m_r[j]     <= erm_pkg::sat_shr12(erm_pkg::ACC_W'(czp0_r[j]) -
                                       erm_pkg::ACC_W'(szp1_r[j]));
      m_r[3 + j] <= erm_pkg::sat_shr12(erm_pkg::ACC_W'(szp0_r[j]) +
                                       erm_pkg::ACC_W'(czp1_r[j]));
      m_r[6 + j] <= p2_r[j];
    end
  end

  assign m_o = m_r;

endmodule

[hdl/euler_rotation_matrix_builder.sv]
// Top level of the Euler rotation matrix builder: three angle lanes and the matrix merge.
//
// Raise start with three angles (4096 units a turn, low 12 bits used) and the item is taken
// at that clock edge whenever busy is low; busy is high only during reset and the cycle after
// it, so one item can be given every cycle. Each item yields one result: the nine elements of
// Rz*(Rx*Ry) in signed 1.3.12, row-major on out_m11..out_m33, shown for exactly one cycle
// with out_valid high once the item has left the pipeline. The receiver cannot hold results
// off, so sample them in that cycle. Three lanes, one per axis, each read sine and cosine from
// a 1025-entry quarter-wave ROM through its two read ports into a register and then fold the
// quadrant into the lane's output register; the merge stage registers the Rx*Ry products,
// then the Rz products and then the sums, shifts and saturation. The rate is one item per
// cycle outside reset, as the lanes and the merge stage are fully pipelined.
module euler_rotation_matrix_builder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [erm_pkg::ANGLE_W-1:0] in_angle_x,
  input  logic signed [erm_pkg::ANGLE_W-1:0] in_angle_y,
  input  logic signed [erm_pkg::ANGLE_W-1:0] in_angle_z,
  output logic                               out_valid,
  output logic signed [erm_pkg::ELEM_W-1:0]  out_m11,
  output logic signed [erm_pkg::ELEM_W-1:0]  out_m12,
  output logic signed [erm_pkg::ELEM_W-1:0]  out_m13,
  output logic signed [erm_pkg::ELEM_W-1:0]  out_m21,
  output logic signed [erm_pkg::ELEM_W-1:0]  out_m22,
  output logic signed [erm_pkg::ELEM_W-1:0]  out_m23,
  output logic signed [erm_pkg::ELEM_W-1:0]  out_m31,
  output logic signed [erm_pkg::ELEM_W-1:0]  out_m32,
  output logic signed [erm_pkg::ELEM_W-1:0]  out_m33
);

  logic                            busy_r;
  logic [erm_pkg::LATENCY-1:0]     vld_r;
  logic [erm_pkg::LATENCY-1:0]     vld_nxt;
  logic                            accept;
  erm_pkg::sc_t                    sc_x;
  erm_pkg::sc_t                    sc_y;
  erm_pkg::sc_t                    sc_z;
  erm_pkg::elem_t                  m [9];

  // hold busy while in reset and drop it in the cycle after reset ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // advance the item's valid flag alongside the datapath stages
  assign vld_nxt = {vld_r[erm_pkg::LATENCY-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // one lane per axis; each works every cycle, the valid flags say which items count
  erm_sincos_lane u_lane_x (
    .clk     (clk),
    .angle_i (in_angle_x),
    .sc_o    (sc_x)
  );

  erm_sincos_lane u_lane_y (
    .clk     (clk),
    .angle_i (in_angle_y),
    .sc_o    (sc_y)
  );

  erm_sincos_lane u_lane_z (
    .clk     (clk),
    .angle_i (in_angle_z),
    .sc_o    (sc_z)
  );

  // combine the three lanes into the rotation matrix
  erm_mat_merge u_merge (
    .clk    (clk),
    .sc_x_i (sc_x),
    .sc_y_i (sc_y),
    .sc_z_i (sc_z),
    .m_o    (m)
  );

  assign out_valid = vld_r[erm_pkg::LATENCY-1];
  assign out_m11   = m[0];
  assign out_m12   = m[1];
  assign out_m13   = m[2];
  assign out_m21   = m[3];
  assign out_m22   = m[4];
  assign out_m23   = m[5];
  assign out_m31   = m[6];
  assign out_m32   = m[7];
  assign out_m33   = m[8];

endmodule

[hdl/erm_checker.sv]
// Port-level checker for the Euler rotation matrix builder, with its bind.
module erm_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic signed [erm_pkg::ANGLE_W-1:0] in_angle_x,
  input logic signed [erm_pkg::ANGLE_W-1:0] in_angle_y,
  input logic signed [erm_pkg::ANGLE_W-1:0] in_angle_z,
  input logic                               out_valid,
  input logic signed [erm_pkg::ELEM_W-1:0]  out_m11,
  input logic signed [erm_pkg::ELEM_W-1:0]  out_m12,
  input logic signed [erm_pkg::ELEM_W-1:0]  out_m13,
  input logic signed [erm_pkg::ELEM_W-1:0]  out_m21,
  input logic signed [erm_pkg::ELEM_W-1:0]  out_m22,
  input logic signed [erm_pkg::ELEM_W-1:0]  out_m23,
  input logic signed [erm_pkg::ELEM_W-1:0]  out_m31,
  input logic signed [erm_pkg::ELEM_W-1:0]  out_m32,
  input logic signed [erm_pkg::ELEM_W-1:0]  out_m33
);

  logic acc;
  logic zero_ang;

  assign acc      = start && !busy;
  assign zero_ang = (in_angle_x[erm_pkg::PHASE_W-1:0] == '0) &&
                    (in_angle_y[erm_pkg::PHASE_W-1:0] == '0) &&
                    (in_angle_z[erm_pkg::PHASE_W-1:0] == '0);

  // busy only in the cycle that follows reset
  a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> $past(!rst_n))
    else $error("busy high outside the cycle after reset");

  // every item gives its result after the fixed latency
  a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##5 out_valid)
    else $error("item taken without a result five cycles later");

  // no result without a matching item taken earlier
  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, 5))
    else $error("result shown without a matching item");

  // zero angles give the identity matrix
  a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(acc && zero_ang, 5)) |->
      (out_m11 == 16'sd4096) && (out_m22 == 16'sd4096) && (out_m33 == 16'sd4096) &&
      (out_m12 == 16'sd0) && (out_m13 == 16'sd0) && (out_m21 == 16'sd0) &&
      (out_m23 == 16'sd0) && (out_m31 == 16'sd0) && (out_m32 == 16'sd0))
    else $error("zero angles did not give the identity matrix");

endmodule

bind euler_rotation_matrix_builder erm_checker u_erm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_angle_x (in_angle_x),
  .in_angle_y (in_angle_y),
  .in_angle_z (in_angle_z),
  .out_valid  (out_valid),
  .out_m11    (out_m11),
  .out_m12    (out_m12),
  .out_m13    (out_m13),
  .out_m21    (out_m21),
  .out_m22    (out_m22),
  .out_m23    (out_m23),
  .out_m31    (out_m31),
  .out_m32    (out_m32),
  .out_m33    (out_m33)
);

[sim/euler_rotation_matrix_builder_test.sv]
// Self-checking testbench of the Euler rotation matrix builder: queue-fed driver, strobe monitor.
module euler_rotation_matrix_builder_test;

  localparam int  NUM_RANDOM  = 450;
  localparam int  GAP_MAX     = 18;
  localparam real HALF_TURN   = 3.14159265358979323846;
  localparam int  TURN_MASK   = 4095;
  localparam int  QUARTER     = 1024;
  localparam int  UNIT        = 4096;
  localparam int  REPORT_MAX  = 10;

  // one pending item: three raw angles and the idle cycles to insert before it
  typedef struct packed {
    logic [erm_pkg::ANGLE_W-1:0] ax;
    logic [erm_pkg::ANGLE_W-1:0] ay;
    logic [erm_pkg::ANGLE_W-1:0] az;
    logic [4:0]                  gap;
  } angle_item_t;

  // nine elements, index 0 is m11, index 8 is m33 (row-major)
  typedef erm_pkg::elem_t [8:0] matrix_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic signed [erm_pkg::ANGLE_W-1:0] in_angle_x = '0;
  logic signed [erm_pkg::ANGLE_W-1:0] in_angle_y = '0;
  logic signed [erm_pkg::ANGLE_W-1:0] in_angle_z = '0;
  logic                               out_valid;
  erm_pkg::elem_t                     out_m11, out_m12, out_m13;
  erm_pkg::elem_t                     out_m21, out_m22, out_m23;
  erm_pkg::elem_t                     out_m31, out_m32, out_m33;

  angle_item_t pending_angles[$];
  matrix_t     expected_mats[$];
  int          quarter_sine[0:QUARTER];
  int          fault_cnt = 0;
  int          idle_run = 0;
  logic        taken = 1'b0;

  euler_rotation_matrix_builder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_angle_x (in_angle_x),
    .in_angle_y (in_angle_y),
    .in_angle_z (in_angle_z),
    .out_valid  (out_valid),
    .out_m11    (out_m11),
    .out_m12    (out_m12),
    .out_m13    (out_m13),
    .out_m21    (out_m21),
    .out_m22    (out_m22),
    .out_m23    (out_m23),
    .out_m31    (out_m31),
    .out_m32    (out_m32),
    .out_m33    (out_m33)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sine of k/4096 of a turn in 1.3.12, folded out of the quarter-wave table
  // by quadrant: odd quadrants run the table backwards, the upper half negates.
  function automatic int sine_of(input int k);
    int q;
    int r;
    int v;
    k = k & TURN_MASK;
    q = k / QUARTER;
    r = k % QUARTER;
    v = (q % 2 == 1) ? quarter_sine[QUARTER - r] : quarter_sine[r];
    return (q >= 2) ? -v : v;
  endfunction

  // Drop the 12 fraction bits (floor) and clamp to the signed 16-bit range.
  function automatic int rescale_clamp(input longint s);
    longint v;
    v = s >>> erm_pkg::FRAC_BITS;
    if (v > erm_pkg::ELEM_MAX) v = erm_pkg::ELEM_MAX;
    if (v < erm_pkg::ELEM_MIN) v = erm_pkg::ELEM_MIN;
    return int'(v);
  endfunction

  // Expected matrix Rz * (Rx * Ry) for one set of raw angles.
  function automatic matrix_t rotation_of(input logic [erm_pkg::ANGLE_W-1:0] ax,
                                          input logic [erm_pkg::ANGLE_W-1:0] ay,
                                          input logic [erm_pkg::ANGLE_W-1:0] az);
    longint  rx[9];
    longint  ry[9];
    longint  rz[9];
    longint  rxy[9];
    longint  acc;
    int      sx, cx, sy, cy, sz, cz;
    int      i, j, k;
    matrix_t res;
    sx = sine_of(ax[erm_pkg::PHASE_W-1:0]);
    cx = sine_of(ax[erm_pkg::PHASE_W-1:0] + QUARTER);
    sy = sine_of(ay[erm_pkg::PHASE_W-1:0]);
    cy = sine_of(ay[erm_pkg::PHASE_W-1:0] + QUARTER);
    sz = sine_of(az[erm_pkg::PHASE_W-1:0]);
    cz = sine_of(az[erm_pkg::PHASE_W-1:0] + QUARTER);
    rx = '{UNIT, 0, 0,   0, cx, -sx,   0, sx, cx};
    ry = '{cy, 0, sy,    0, UNIT, 0,   -sy, 0, cy};
    rz = '{cz, -sz, 0,   sz, cz, 0,    0, 0, UNIT};
    // first product: Rx * Ry, each element rescaled and clamped
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        acc = 0;
        for (k = 0; k < 3; k++) acc += rx[i*3+k] * ry[k*3+j];
        rxy[i*3+j] = rescale_clamp(acc);
      end
    end
    // second product: Rz applied on the left
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        acc = 0;
        for (k = 0; k < 3; k++) acc += rz[i*3+k] * rxy[k*3+j];
        res[i*3+j] = erm_pkg::elem_t'(rescale_clamp(acc));
      end
    end
    return res;
  endfunction

  task automatic push_item(input logic [erm_pkg::ANGLE_W-1:0] ax,
                           input logic [erm_pkg::ANGLE_W-1:0] ay,
                           input logic [erm_pkg::ANGLE_W-1:0] az, input int gap);
    angle_item_t it;
    it.ax  = ax;
    it.ay  = ay;
    it.az  = az;
    it.gap = 5'(gap);
    pending_angles.push_back(it);
  endtask

  // Angle with bias towards quadrant and octant edges; upper bits stay random
  // so that the reduction to one turn is always exercised.
  function automatic logic [erm_pkg::ANGLE_W-1:0] pick_angle();
    logic [erm_pkg::ANGLE_W-1:0] a;
    a = erm_pkg::ANGLE_W'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        a[erm_pkg::PHASE_W-1:0] =
            erm_pkg::PHASE_W'($urandom_range(0, 7) * 512 + $urandom_range(0, 4) - 2);
      end
      1: begin
        a[erm_pkg::PHASE_W-1:0] = erm_pkg::PHASE_W'($urandom_range(0, 6) - 3);
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  task automatic note_fault(input string what);
    fault_cnt++;
    if (fault_cnt <= REPORT_MAX) $display("%s", what);
  endtask

  // Monitor and scoreboard: check the strobed result against the oldest
  // expectation, then record a prediction for any item taken at this edge.
  always @(posedge clk) begin
    matrix_t seen;
    matrix_t want;
    int      e;
    if (out_valid === 1'b1) begin
      seen = {out_m33, out_m32, out_m31, out_m23, out_m22, out_m21, out_m13, out_m12, out_m11};
      if (expected_mats.size() == 0) begin
        note_fault($sformatf("unexpected result at %0t: %p", $time, seen));
      end else begin
        want = expected_mats.pop_front();
        for (e = 0; e < 9; e++) begin
          if (seen[e] !== want[e]) begin
            note_fault($sformatf("m%0d%0d mismatch at %0t: expected %0d, got %0d",
                                 e / 3 + 1, e % 3 + 1, $time, want[e], seen[e]));
          end
        end
      end
    end
    taken = rst_n && start && !busy;
    if (taken) expected_mats.push_back(rotation_of(in_angle_x, in_angle_y, in_angle_z));
  end

  // Driver: hold an item until it is taken, insert the idle cycles asked for
  // before the next one, and put noise on the angle ports while idle.
  always @(negedge clk) begin
    angle_item_t head;
    if (rst_n && (!start || taken)) begin
      if (pending_angles.size() != 0 && idle_run >= pending_angles[0].gap) begin
        head = pending_angles.pop_front();
        start      <= 1'b1;
        in_angle_x <= head.ax;
        in_angle_y <= head.ay;
        in_angle_z <= head.az;
        idle_run = 0;
      end else begin
        start      <= 1'b0;
        in_angle_x <= erm_pkg::ANGLE_W'($urandom);
        in_angle_y <= erm_pkg::ANGLE_W'($urandom);
        in_angle_z <= erm_pkg::ANGLE_W'($urandom);
        if (pending_angles.size() != 0) idle_run++;
      end
    end
  end

  initial begin
    int r;
    int n;
    int mode;
    int gap;
    // quarter-wave sine table, round to nearest (no entry sits on a tie)
    for (r = 0; r <= QUARTER; r++) begin
      quarter_sine[r] = $rtoi($floor(4096.0 * $sin(HALF_TURN * r / 2048.0) + 0.5));
    end

    // directed: zero, each axis alone at a quarter turn, quadrant and octant
    // edges, the last step of a turn, extreme 16-bit patterns and angles
    // beyond one turn that must wrap
    push_item(16'h0000, 16'h0000, 16'h0000, 0);
    push_item(16'd1024, 16'h0000, 16'h0000, 0);
    push_item(16'h0000, 16'd1024, 16'h0000, 3);
    push_item(16'h0000, 16'h0000, 16'd1024, 0);
    push_item(16'd2048, 16'd2048, 16'd2048, GAP_MAX);
    push_item(16'd3072, 16'd3072, 16'd3072, 0);
    push_item(16'd4095, 16'd4095, 16'd4095, 1);
    push_item(16'd512,  16'd512,  16'd512,  0);
    push_item(16'd511,  16'd513,  16'd1023, 0);
    push_item(16'd1025, 16'd2047, 16'd2049, 7);
    push_item(16'd3071, 16'd3073, 16'd1,    0);
    push_item(16'h7FFF, 16'h8000, 16'hFFFF, 0);
    push_item(16'h8000, 16'h7FFF, 16'h1000, 2);
    push_item(16'h1000, 16'hF000, 16'hAAAA, 0);
    push_item(16'h5555, 16'hAAAA, 16'h5555, 0);
    push_item(16'd683,  16'd1365, 16'd2731, 11);
    push_item(16'd256,  16'd768,  16'd3840, 0);
    push_item(16'hF400, 16'h0C00, 16'h0400, 0);
    push_item(16'hFFFF, 16'hFFFF, 16'h8000, 0);

    // random: the idling style changes every few dozen items so that both
    // back-to-back bursts and long gaps fall on every pipeline stage
    mode = 0;
    for (n = 0; n < NUM_RANDOM; n++) begin
      if (n % 30 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0:       gap = 0;
        1:       gap = $urandom_range(0, GAP_MAX);
        default: gap = $urandom_range(0, 3);
      endcase
      push_item(pick_angle(), pick_angle(), pick_angle(), gap);
    end

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // wait until every item is taken and every result has come back
    while (pending_angles.size() != 0 || start) @(posedge clk);
    while (expected_mats.size() != 0) @(posedge clk);
    repeat (erm_pkg::LATENCY + 3) @(posedge clk);

    if (fault_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard limit: well beyond the slowest correct run
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
hdl/erm_pkg.sv
hdl/erm_sincos_lane.sv
hdl/erm_mat_merge.sv
hdl/euler_rotation_matrix_builder.sv
hdl/erm_checker.sv
sim/euler_rotation_matrix_builder_test.sv
